// ===== hdl/frc_pkg.sv =====
// Shared types, constants and helpers for the fog relay cycle controller.
`default_nettype none

package frc_pkg;

    // Millisecond ticks in one second of a timer phase
    localparam int unsigned TICKS_PER_SECOND = 1000;

    // Phase countdown ceiling in ticks (26 bits)
    localparam logic [25:0] CD_MAX = 26'h3FF_FFFF;

    // The countdown is held as whole seconds plus a sub-second tick count
    localparam int SUB_W = (TICKS_PER_SECOND > 1) ? $clog2(TICKS_PER_SECOND) : 1;
    localparam logic [25:0] SEC_LIMIT = 26'(CD_MAX / TICKS_PER_SECOND);
    localparam logic [SUB_W-1:0] SUB_AT_LIMIT = SUB_W'(CD_MAX % TICKS_PER_SECOND);
    localparam logic [SUB_W-1:0] SUB_TOP = SUB_W'(TICKS_PER_SECOND - 1);

    // Configuration reset values
    localparam logic [9:0]  HOT_RESET   = 10'd600;
    localparam logic [9:0]  COLD_RESET  = 10'd100;
    localparam logic [15:0] QUICK_RESET = 16'd2000;

    // Most results one item can cause
    localparam int MSG_SLOTS = 4;

    typedef enum logic [2:0] {
        CMD_TICK   = 3'd0,
        CMD_LOCK   = 3'd1,
        CMD_UNLOCK = 3'd2,
        CMD_QUICK  = 3'd3,
        CMD_MANUAL = 3'd4,
        CMD_RESET  = 3'd5,
        CMD_REFRESH = 3'd6,
        CMD_TIMER  = 3'd7
    } cmd_t;

    typedef enum logic [2:0] {
        MSG_READY    = 3'd0,
        MSG_COLD     = 3'd1,
        MSG_LOCKED   = 3'd2,
        MSG_UNLOCKED = 3'd3,
        MSG_FOG      = 3'd4,
        MSG_MANUAL   = 3'd5,
        MSG_RESET    = 3'd6,
        MSG_TIMER    = 3'd7
    } msg_t;

    typedef enum logic [1:0] {
        CFG_HOT   = 2'd0,
        CFG_COLD  = 2'd1,
        CFG_QUICK = 2'd2,
        CFG_NONE  = 2'd3
    } cfg_idx_t;

    // Classified item as it waits in the queue
    typedef struct packed {
        cmd_t        cmd;
        logic [9:0]  sample;
        logic [15:0] on_s;
        logic [15:0] off_s;
        logic        lens_ok;
    } item_t;

    // Configuration values seen by the executor
    typedef struct packed {
        logic [9:0]  hot;
        logic [9:0]  cold;
        logic [15:0] quick_ms;
    } cfg_t;

    // Phase countdown in seconds and sub-second ticks
    typedef struct packed {
        logic [15:0]      sec;
        logic [SUB_W-1:0] sub;
    } phase_t;

    // Load a phase of the given length, saturating at the countdown ceiling
    function automatic phase_t phase_load(input logic [15:0] secs);
        phase_t p;
        if ({10'd0, secs} > SEC_LIMIT)
        begin
            p.sec = SEC_LIMIT[15:0];
            p.sub = SUB_AT_LIMIT;
        end
        else
        begin
            p.sec = secs;
            p.sub = '0;
        end
        return p;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/frc_front.sv =====
// Front end: accepts input transfers, classifies them and queues them.
`default_nettype none

module frc_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  wire logic [47:0]   s_tdata,  // heat_sample[9:0], on_seconds[25:10], off_seconds[41:26]
    input  wire logic [7:0]    s_tuser,  // command[2:0]
    output logic               q_valid,
    output frc_pkg::item_t     q_item,
    input  wire logic          q_pop
);
    import frc_pkg::*;

    item_t      queue_reg [2];
    logic [1:0] cnt_reg, cnt_next;
    logic       wr_ptr_reg, rd_ptr_reg;
    logic       push;
    item_t      item_in;

    // Classify the incoming transfer
    always_comb
    begin
        item_in.cmd     = cmd_t'(s_tuser[2:0]);
        item_in.sample  = s_tdata[9:0];
        item_in.on_s    = s_tdata[25:10];
        item_in.off_s   = s_tdata[41:26];
        item_in.lens_ok = (s_tdata[25:10] != 16'd0) && (s_tdata[41:26] != 16'd0);
    end

    assign s_tready = (cnt_reg != 2'd2);
    assign push     = s_tvalid && s_tready;
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_item   = queue_reg[rd_ptr_reg];

    // Occupancy
    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !(q_pop && q_valid))
            cnt_next = cnt_reg + 2'd1;
        else if (!push && q_pop && q_valid)
            cnt_next = cnt_reg - 2'd1;
    end

    // Queue pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg    <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (q_pop && q_valid)
                rd_ptr_reg <= !rd_ptr_reg;
        end
    end

    // Queue storage
    always_ff @(posedge clk)
    begin
        if (push)
            queue_reg[wr_ptr_reg] <= item_in;
    end

endmodule

`default_nettype wire

// ===== hdl/frc_back.sv =====
// Back end: executes queued items, keeps the machine state and emits messages.
`default_nettype none

module frc_back (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire frc_pkg::cfg_t cfg,
    input  wire logic          q_valid,
    input  wire frc_pkg::item_t q_item,
    output logic               q_pop,
    output logic               m_tvalid,
    input  wire logic          m_tready,
    output logic [23:0]        m_tdata,  // relay_on[0], seconds_left[16:1]
    output logic [7:0]         m_tuser,  // message[2:0]
    output logic               m_tlast
);
    import frc_pkg::*;

    // Machine state
    logic             locked_reg, locked_next;
    logic             fogging_reg, fogging_next;
    logic             timer_active_reg, timer_active_next;
    logic             quick_active_reg, quick_active_next;
    logic             heated_reg, heated_next;
    logic [9:0]       last_sample_reg, last_sample_next;
    phase_t           phase_reg, phase_next;
    logic [15:0]      quick_cnt_reg, quick_cnt_next;
    logic [15:0]      on_len_reg, on_len_next;
    logic [15:0]      off_len_reg, off_len_next;

    // Message buffer for the item in progress
    msg_t             buf_msg_reg  [MSG_SLOTS];
    logic [15:0]      buf_secs_reg [MSG_SLOTS];
    logic             buf_relay_reg;
    logic [2:0]       buf_cnt_reg;
    logic [1:0]       buf_idx_reg;

    // Output register
    logic             m_valid_reg;
    logic             m_relay_reg;
    msg_t             m_msg_reg;
    logic [15:0]      m_secs_reg;
    logic             m_last_reg;

    // Executor results
    msg_t             mc [MSG_SLOTS];
    logic [15:0]      ms [MSG_SLOTS];
    logic [2:0]       n;
    logic             busy, load, last_one;
    phase_t           ld;

    assign busy     = (buf_cnt_reg != 3'd0);
    assign q_pop    = q_valid && !busy;
    assign load     = busy && (!m_valid_reg || m_tready);
    assign last_one = ({1'b0, buf_idx_reg} == (buf_cnt_reg - 3'd1));

    // Execute one item: next state and its list of messages
    always_comb
    begin
        locked_next       = locked_reg;
        fogging_next      = fogging_reg;
        timer_active_next = timer_active_reg;
        quick_active_next = quick_active_reg;
        heated_next       = heated_reg;
        last_sample_next  = last_sample_reg;
        phase_next        = phase_reg;
        quick_cnt_next    = quick_cnt_reg;
        on_len_next       = on_len_reg;
        off_len_next      = off_len_reg;
        ld                = phase_load(16'd0);
        n                 = 3'd0;
        for (int i = 0; i < MSG_SLOTS; i++)
        begin
            mc[i] = MSG_READY;
            ms[i] = 16'd0;
        end

        case (q_item.cmd)
            CMD_TICK:
            begin
                last_sample_next = q_item.sample;
                // timer phase
                if (timer_active_next)
                begin
                    if (phase_next.sec != 16'd0 || phase_next.sub != '0)
                    begin
                        if (phase_next.sub != '0)
                            phase_next.sub = phase_next.sub - SUB_W'(1);
                        else
                        begin
                            phase_next.sec = phase_next.sec - 16'd1;
                            phase_next.sub = SUB_TOP;
                        end
                    end
                    else if (!fogging_next && heated_next)
                    begin
                        fogging_next = 1'b1;
                        ld           = phase_load(on_len_next);
                        phase_next   = ld;
                        mc[n[1:0]]   = MSG_FOG;
                        n            = n + 3'd1;
                    end
                    else
                    begin
                        fogging_next = 1'b0;
                        ld           = phase_load(off_len_next);
                        phase_next   = ld;
                        mc[n[1:0]]   = MSG_TIMER;
                        ms[n[1:0]]   = off_len_next;
                        n            = n + 3'd1;
                    end
                end
                // quick burst
                if (quick_active_next)
                begin
                    if (quick_cnt_next <= 16'd1)
                    begin
                        quick_active_next = 1'b0;
                        quick_cnt_next    = 16'd0;
                        if (timer_active_next)
                        begin
                            mc[n[1:0]] = MSG_TIMER;
                            ms[n[1:0]] = phase_next.sec;
                        end
                        else
                            mc[n[1:0]] = MSG_RESET;
                        n            = n + 3'd1;
                        fogging_next = 1'b0;
                    end
                    else
                        quick_cnt_next = quick_cnt_next - 16'd1;
                end
                // heat hysteresis
                if (q_item.sample > cfg.hot && !heated_next)
                begin
                    heated_next = 1'b1;
                    mc[n[1:0]]  = MSG_READY;
                    n           = n + 3'd1;
                    if (fogging_next)
                    begin
                        mc[n[1:0]] = timer_active_next ? MSG_FOG : MSG_MANUAL;
                        n          = n + 3'd1;
                    end
                end
                else if (q_item.sample < cfg.cold && heated_next)
                begin
                    heated_next = 1'b0;
                    mc[n[1:0]]  = MSG_COLD;
                    n           = n + 3'd1;
                end
            end
            CMD_LOCK:
            begin
                if (!locked_reg)
                begin
                    locked_next       = 1'b1;
                    timer_active_next = 1'b0;
                    fogging_next      = 1'b0;
                    phase_next        = phase_load(16'd0);
                    mc[0]             = MSG_LOCKED;
                    n                 = 3'd1;
                end
            end
            CMD_UNLOCK:
            begin
                if (locked_reg)
                begin
                    locked_next = 1'b0;
                    mc[0]       = MSG_UNLOCKED;
                    n           = 3'd1;
                end
            end
            CMD_QUICK:
            begin
                if (!locked_reg && heated_reg && !quick_active_reg)
                begin
                    fogging_next      = 1'b1;
                    quick_active_next = 1'b1;
                    quick_cnt_next    = cfg.quick_ms;
                    mc[0]             = MSG_FOG;
                    n                 = 3'd1;
                end
            end
            CMD_MANUAL:
            begin
                if (!locked_reg && heated_reg && !timer_active_reg)
                begin
                    fogging_next = !fogging_reg;
                    mc[0]        = fogging_reg ? MSG_RESET : MSG_MANUAL;
                    n            = 3'd1;
                end
            end
            CMD_RESET:
            begin
                timer_active_next = 1'b0;
                fogging_next      = 1'b0;
                phase_next        = phase_load(16'd0);
                mc[0]             = MSG_RESET;
                n                 = 3'd1;
            end
            CMD_REFRESH:
            begin
                if (last_sample_reg > cfg.hot)
                begin
                    mc[0] = MSG_READY;
                    n     = 3'd1;
                end
                else if (last_sample_reg < cfg.cold)
                begin
                    mc[0] = MSG_COLD;
                    n     = 3'd1;
                end
                if (locked_reg)
                    mc[n[1:0]] = MSG_LOCKED;
                else if (fogging_reg)
                    mc[n[1:0]] = MSG_FOG;
                else if (timer_active_reg)
                begin
                    mc[n[1:0]] = MSG_TIMER;
                    ms[n[1:0]] = phase_reg.sec;
                end
                else
                    mc[n[1:0]] = MSG_RESET;
                n = n + 3'd1;
            end
            CMD_TIMER:
            begin
                if (!locked_reg && heated_reg && q_item.lens_ok)
                begin
                    timer_active_next = 1'b1;
                    on_len_next       = q_item.on_s;
                    off_len_next      = q_item.off_s;
                    fogging_next      = 1'b0;
                    phase_next        = phase_load(q_item.off_s);
                    mc[0]             = MSG_TIMER;
                    ms[0]             = q_item.off_s;
                    n                 = 3'd1;
                end
            end
            default:
            begin
                n = 3'd0;
            end
        endcase
    end

    // State and buffer control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            locked_reg       <= 1'b0;
            fogging_reg      <= 1'b0;
            timer_active_reg <= 1'b0;
            quick_active_reg <= 1'b0;
            heated_reg       <= 1'b0;
            last_sample_reg  <= 10'd0;
            phase_reg        <= '0;
            quick_cnt_reg    <= 16'd0;
            on_len_reg       <= 16'd0;
            off_len_reg      <= 16'd0;
            buf_cnt_reg      <= 3'd0;
            buf_idx_reg      <= 2'd0;
            m_valid_reg      <= 1'b0;
        end
        else
        begin
            if (q_pop)
            begin
                locked_reg       <= locked_next;
                fogging_reg      <= fogging_next;
                timer_active_reg <= timer_active_next;
                quick_active_reg <= quick_active_next;
                heated_reg       <= heated_next;
                last_sample_reg  <= last_sample_next;
                phase_reg        <= phase_next;
                quick_cnt_reg    <= quick_cnt_next;
                on_len_reg       <= on_len_next;
                off_len_reg      <= off_len_next;
                buf_cnt_reg      <= n;
                buf_idx_reg      <= 2'd0;
            end
            else if (load)
            begin
                if (last_one)
                begin
                    buf_cnt_reg <= 3'd0;
                    buf_idx_reg <= 2'd0;
                end
                else
                    buf_idx_reg <= buf_idx_reg + 2'd1;
            end

            if (load)
                m_valid_reg <= 1'b1;
            else if (m_tready)
                m_valid_reg <= 1'b0;
        end
    end

    // Buffer and output payload
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            buf_relay_reg <= fogging_next;
            for (int i = 0; i < MSG_SLOTS; i++)
            begin
                buf_msg_reg[i]  <= mc[i];
                buf_secs_reg[i] <= ms[i];
            end
        end
        if (load)
        begin
            m_relay_reg <= buf_relay_reg;
            m_msg_reg   <= buf_msg_reg[buf_idx_reg];
            m_secs_reg  <= buf_secs_reg[buf_idx_reg];
            m_last_reg  <= last_one;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'd0, m_secs_reg, m_relay_reg};
    assign m_tuser  = {5'd0, m_msg_reg};
    assign m_tlast  = m_last_reg;

    // Checks
    a_buf_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        buf_cnt_reg <= 3'd4)
        else $error("message buffer count out of range");

    a_buf_idx: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> ({1'b0, buf_idx_reg} < buf_cnt_reg))
        else $error("message index past buffer count");

    a_quick_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !quick_active_reg |-> (quick_cnt_reg == 16'd0))
        else $error("quick countdown left over after burst");

    a_lock_timer: assert property (@(posedge clk) disable iff (!rst_n)
        locked_reg |-> !timer_active_reg)
        else $error("timer running while locked");

endmodule

`default_nettype wire

// ===== hdl/fog_relay_cycle_controller.sv =====
// Top level of the fog relay cycle controller: configuration registers and core.
`default_nettype none

// Relay controller for a heated fog machine. Each input transfer is a
// millisecond tick (carrying a heater sample) or a command; each produces
// zero to four status transfers, the last one flagged with tlast, all
// carrying the relay state left by that input. Inputs are queued two deep
// and then executed. An item holds the executor for its execute step
// alone when it produces no status transfer, and otherwise also until its
// last status transfer has been loaded into the output register; one
// transfer leaves the output register per cycle while the receiver is
// ready, and a new input is taken every cycle while the queue has room.
// Timer phases count down in whole seconds plus sub-second ticks, so
// remaining seconds need no divider. Thresholds and burst length are
// written over the APB port at 0x0, 0x4 and 0x8.

module fog_relay_cycle_controller (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  wire logic [47:0]   s_tdata,  // heat_sample[9:0], on_seconds[25:10], off_seconds[41:26]
    input  wire logic [7:0]    s_tuser,  // command[2:0]
    output logic               m_tvalid,
    input  wire logic          m_tready,
    output logic [23:0]        m_tdata,  // relay_on[0], seconds_left[16:1]
    output logic [7:0]         m_tuser,  // message[2:0]
    output logic               m_tlast,
    input  wire logic          psel,
    input  wire logic          penable,
    input  wire logic          pwrite,
    input  wire logic [3:0]    paddr,
    input  wire logic [31:0]   pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import frc_pkg::*;

    logic [9:0]  hot_reg;
    logic [9:0]  cold_reg;
    logic [15:0] quick_ms_reg;
    cfg_idx_t    cfg_sel;
    logic        cfg_wr;
    cfg_t        cfg;
    logic        q_valid;
    item_t       q_item;
    logic        q_pop;

    assign pready  = 1'b1;
    assign cfg_sel = cfg_idx_t'(paddr[3:2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hot_reg      <= HOT_RESET;
            cold_reg     <= COLD_RESET;
            quick_ms_reg <= QUICK_RESET;
        end
        else if (cfg_wr)
        begin
            case (cfg_sel)
                CFG_HOT:   hot_reg      <= pwdata[9:0];
                CFG_COLD:  cold_reg     <= pwdata[9:0];
                CFG_QUICK: quick_ms_reg <= pwdata[15:0];
                default:   ;
            endcase
        end
    end

    // Register read back
    always_comb
    begin
        case (cfg_sel)
            CFG_HOT:   prdata = {22'd0, hot_reg};
            CFG_COLD:  prdata = {22'd0, cold_reg};
            CFG_QUICK: prdata = {16'd0, quick_ms_reg};
            default:   prdata = 32'd0;
        endcase
    end

    assign cfg.hot      = hot_reg;
    assign cfg.cold     = cold_reg;
    assign cfg.quick_ms = quick_ms_reg;

    frc_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop)
    );

    frc_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire

// ===== sim/fog_relay_cycle_controller_tb.sv =====
// Self-checking testbench for the fog relay cycle controller.
`timescale 1ns / 1ps

module fog_relay_cycle_controller_tb;

    import frc_pkg::*;

    localparam int DIR_ROWS     = 26;
    localparam int DRAIN_CYCLES = 30;
    localparam int HOLD_CYCLES  = 300;
    localparam int MAX_REPORTS  = 10;
    localparam int PHASE_ITEMS  = 20;
    localparam int N_PHASES     = 5;

    // One input transfer, optionally with a hand-written expectation
    typedef struct {
        cmd_t        cmd;
        logic [9:0]  sample;
        logic [15:0] on_s;
        logic [15:0] off_s;
        bit          typed;
        int          n_exp;
        logic        relay;
        msg_t        msg;
        logic [15:0] secs;
    } stim_t;

    // One status transfer as it should leave the block
    typedef struct {
        logic        relay;
        msg_t        msg;
        logic [15:0] secs;
        logic        last;
    } status_t;

    typedef enum int {
        RX_ALWAYS,
        RX_HALF,
        RX_SPARSE,
        RX_MOSTLY
    } rx_mode_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;  // heat_sample[9:0], on_seconds[25:10], off_seconds[41:26]
    logic [7:0]  s_tuser = '0;  // command[2:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;       // relay_on[0], seconds_left[16:1]
    logic [7:0]  m_tuser;       // message[2:0]
    logic        m_tlast;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    fog_relay_cycle_controller u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #4 clk = ~clk;

    // Predicted controller state and register copies
    logic [9:0]  cfg_hot = HOT_RESET;
    logic [9:0]  cfg_cold = COLD_RESET;
    logic [15:0] cfg_quick = QUICK_RESET;
    logic        st_locked = 1'b0;
    logic        st_fog = 1'b0;
    logic        st_timer = 1'b0;
    logic        st_burst = 1'b0;
    logic        st_heated = 1'b0;
    logic [9:0]  st_sample = '0;
    logic [25:0] st_phase = '0;
    logic [15:0] st_burst_cd = '0;
    logic [15:0] st_on_len = '0;
    logic [15:0] st_off_len = '0;

    msg_t        item_msgs[$];
    logic [15:0] item_secs[$];
    status_t     status_q[$];

    int          err_cnt = 0;
    int          burst_left = 0;
    bit          hold_req = 1'b0;
    logic        long_hold = 1'b0;
    rx_mode_t    rx_mode = RX_ALWAYS;
    int          rx_count = 0;
    stim_t       dir_tab[DIR_ROWS];

    task automatic report(input string text);
        err_cnt++;
        if (err_cnt <= MAX_REPORTS)
            $display("mismatch: %s", text);
    endtask

    function automatic logic [25:0] ticks_of(input logic [15:0] secs);
        longint unsigned t;
        t = longint'(secs) * TICKS_PER_SECOND;
        return (t > CD_MAX) ? CD_MAX : t[25:0];
    endfunction

    function automatic logic [15:0] secs_remaining();
        longint unsigned s;
        s = st_phase / TICKS_PER_SECOND;
        return (s > 65535) ? 16'hFFFF : s[15:0];
    endfunction

    task automatic note_msg(input msg_t m, input logic [15:0] secs);
        if (item_msgs.size() < 6)
        begin
            item_msgs.push_back(m);
            item_secs.push_back(secs);
        end
    endtask

    // Millisecond tick: timer phase, burst countdown, then heat hysteresis
    task automatic tick_state(input logic [9:0] smp);
        st_sample = smp;
        if (st_timer)
        begin
            if (st_phase != 0)
                st_phase--;
            else if (!st_fog && st_heated)
            begin
                st_fog = 1'b1;
                st_phase = ticks_of(st_on_len);
                note_msg(MSG_FOG, 16'd0);
            end
            else
            begin
                st_fog = 1'b0;
                st_phase = ticks_of(st_off_len);
                note_msg(MSG_TIMER, st_off_len);
            end
        end
        if (st_burst)
        begin
            if (st_burst_cd <= 1)
            begin
                st_burst = 1'b0;
                st_burst_cd = '0;
                if (st_timer)
                    note_msg(MSG_TIMER, secs_remaining());
                else
                    note_msg(MSG_RESET, 16'd0);
                st_fog = 1'b0;
            end
            else
                st_burst_cd--;
        end
        if (smp > cfg_hot && !st_heated)
        begin
            st_heated = 1'b1;
            note_msg(MSG_READY, 16'd0);
            if (st_fog)
                note_msg(st_timer ? MSG_FOG : MSG_MANUAL, 16'd0);
        end
        else if (smp < cfg_cold && st_heated)
        begin
            st_heated = 1'b0;
            note_msg(MSG_COLD, 16'd0);
        end
    endtask

    // Work out the status transfers of one accepted input and queue them
    task automatic predict_status(input stim_t it);
        status_t s;
        item_msgs.delete();
        item_secs.delete();
        case (it.cmd)
            CMD_TICK:
                tick_state(it.sample);
            CMD_LOCK:
                if (!st_locked)
                begin
                    st_locked = 1'b1;
                    st_timer = 1'b0;
                    st_fog = 1'b0;
                    st_phase = '0;
                    note_msg(MSG_LOCKED, 16'd0);
                end
            CMD_UNLOCK:
                if (st_locked)
                begin
                    note_msg(MSG_UNLOCKED, 16'd0);
                    st_locked = 1'b0;
                end
            CMD_QUICK:
                if (!st_locked && st_heated && !st_burst)
                begin
                    st_fog = 1'b1;
                    st_burst = 1'b1;
                    st_burst_cd = cfg_quick;
                    note_msg(MSG_FOG, 16'd0);
                end
            CMD_MANUAL:
                if (!st_locked && st_heated && !st_timer)
                begin
                    st_fog = !st_fog;
                    note_msg(st_fog ? MSG_MANUAL : MSG_RESET, 16'd0);
                end
            CMD_RESET:
            begin
                st_timer = 1'b0;
                st_fog = 1'b0;
                st_phase = '0;
                note_msg(MSG_RESET, 16'd0);
            end
            CMD_REFRESH:
            begin
                if (st_sample > cfg_hot)
                    note_msg(MSG_READY, 16'd0);
                else if (st_sample < cfg_cold)
                    note_msg(MSG_COLD, 16'd0);
                if (st_locked)
                    note_msg(MSG_LOCKED, 16'd0);
                else if (st_fog)
                    note_msg(MSG_FOG, 16'd0);
                else if (st_timer)
                    note_msg(MSG_TIMER, secs_remaining());
                else
                    note_msg(MSG_RESET, 16'd0);
            end
            default:
                if (!st_locked && st_heated && it.on_s != 0 && it.off_s != 0)
                begin
                    st_timer = 1'b1;
                    st_on_len = it.on_s;
                    st_off_len = it.off_s;
                    st_fog = 1'b0;
                    st_phase = ticks_of(it.off_s);
                    note_msg(MSG_TIMER, it.off_s);
                end
        endcase

        if (it.typed)
        begin
            // hand-written rows must agree with the prediction as well
            if (item_msgs.size() != it.n_exp || (it.n_exp == 1 && (item_msgs[0] != it.msg
                || item_secs[0] != it.secs || st_fog != it.relay)))
                report($sformatf("directed %s row disagrees with prediction", it.cmd.name()));
            if (it.n_exp == 1)
            begin
                s.relay = it.relay;
                s.msg = it.msg;
                s.secs = it.secs;
                s.last = 1'b1;
                status_q.push_back(s);
            end
        end
        else
        begin
            foreach (item_msgs[k])
            begin
                s.relay = st_fog;
                s.msg = item_msgs[k];
                s.secs = item_secs[k];
                s.last = (k == item_msgs.size() - 1);
                status_q.push_back(s);
            end
        end
    endtask

    function automatic stim_t item_of(input cmd_t c, input logic [9:0] smp,
                                      input logic [15:0] on_s, input logic [15:0] off_s);
        stim_t it;
        it.cmd = c;
        it.sample = smp;
        it.on_s = on_s;
        it.off_s = off_s;
        it.typed = 1'b0;
        it.n_exp = 0;
        it.relay = 1'b0;
        it.msg = MSG_READY;
        it.secs = '0;
        return it;
    endfunction

    function automatic stim_t typed_row(input cmd_t c, input logic [9:0] smp,
                                        input logic [15:0] on_s, input logic [15:0] off_s,
                                        input int n, input logic relay, input msg_t m,
                                        input logic [15:0] secs);
        stim_t it;
        it = item_of(c, smp, on_s, off_s);
        it.typed = 1'b1;
        it.n_exp = n;
        it.relay = relay;
        it.msg = m;
        it.secs = secs;
        return it;
    endfunction

    // Offer one input in bursts with random gaps; called at a rising edge
    task automatic drive_item(input stim_t it);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata <= {6'd0, it.off_s, it.on_s, it.sample};
        s_tuser <= {5'd0, it.cmd};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predict_status(it);
    endtask

    task automatic apb_write(input cfg_idx_t idx, input logic [31:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            CFG_HOT:   cfg_hot = val[9:0];
            CFG_COLD:  cfg_cold = val[9:0];
            CFG_QUICK: cfg_quick = val[15:0];
            default:   ;
        endcase
    endtask

    // Let every expected transfer arrive, then let silent items drain
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (status_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic logic [9:0] hot_sample();
        if (cfg_hot == 10'h3FF || $urandom_range(0, 19) == 0)
            return 10'($urandom());
        return 10'($urandom_range(cfg_hot + 1, 1023));
    endfunction

    function automatic logic [15:0] pick_len();
        case ($urandom_range(0, 5))
            0:       return 16'd0;
            1:       return 16'($urandom());
            2:       return 16'hFFFF;
            default: return 16'($urandom_range(1, 3));
        endcase
    endfunction

    // Hot ticks with the odd refresh mixed in
    task automatic tick_run(input int len);
        repeat (len)
        begin
            if ($urandom_range(0, 99) == 0)
                drive_item(item_of(CMD_REFRESH, 10'($urandom()), 16'($urandom()),
                                   16'($urandom())));
            else
                drive_item(item_of(CMD_TICK, hot_sample(), 16'($urandom()), 16'($urandom())));
        end
    endtask

    // Well-formed timer and burst sequences for half the picks, random commands for the rest
    task automatic random_phase(input int n_items);
        int  i;
        int  kind;
        int  len;
        i = 0;
        while (i < n_items)
        begin
            kind = $urandom_range(0, 9);
            if (kind < 3)
            begin
                drive_item(item_of(CMD_UNLOCK, 10'($urandom()), 16'($urandom()), 16'($urandom())));
                drive_item(item_of(CMD_TICK, hot_sample(), 16'($urandom()), 16'($urandom())));
                drive_item(item_of(CMD_TIMER, 10'($urandom()), 16'($urandom_range(1, 2)),
                                   16'($urandom_range(1, 2))));
                len = $urandom_range(3, 12);
                tick_run(len);
                drive_item(item_of(CMD_REFRESH, 10'($urandom()), 16'($urandom()),
                                   16'($urandom())));
                i += len + 4;
            end
            else if (kind < 5)
            begin
                drive_item(item_of(CMD_UNLOCK, 10'($urandom()), 16'($urandom()), 16'($urandom())));
                drive_item(item_of(CMD_TICK, hot_sample(), 16'($urandom()), 16'($urandom())));
                drive_item(item_of(CMD_QUICK, 10'($urandom()), 16'($urandom()), 16'($urandom())));
                if (cfg_quick <= 16)
                    len = cfg_quick + $urandom_range(0, 3);
                else
                    len = $urandom_range(2, 12);
                tick_run(len);
                i += len + 3;
            end
            else
            begin
                drive_item(item_of(cmd_t'($urandom_range(0, 7)),
                                   ($urandom_range(0, 2) == 0) ? hot_sample() : 10'($urandom()),
                                   pick_len(), pick_len()));
                i++;
            end
        end
    endtask

    // Receiver: ready pattern is redrawn each time its random hold count runs out
    always @(posedge clk)
    begin
        if (rx_count == 0)
        begin
            rx_mode <= rx_mode_t'($urandom_range(0, 3));
            rx_count <= $urandom_range(8, 64);
        end
        else
            rx_count <= rx_count - 1;
        if (long_hold)
            m_tready <= 1'b0;
        else
            case (rx_mode)
                RX_ALWAYS: m_tready <= 1'b1;
                RX_HALF:   m_tready <= 1'($urandom_range(0, 1));
                RX_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
                default:   m_tready <= ($urandom_range(0, 7) != 0);
            endcase
    end

    // One long hold-off on the output, so the input side backs up
    initial
    begin
        wait (hold_req);
        @(posedge clk);
        long_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        long_hold <= 1'b0;
    end

    // Compare every status transfer with the oldest expectation
    always @(posedge clk)
    begin
        status_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (status_q.size() == 0)
                report($sformatf("unexpected transfer: msg %0d secs %0d relay %0b last %0b",
                                 m_tuser[2:0], m_tdata[16:1], m_tdata[0], m_tlast));
            else
            begin
                want = status_q.pop_front();
                if (m_tdata[0] !== want.relay)
                    report($sformatf("relay_on expected %0b, got %0b", want.relay, m_tdata[0]));
                if (m_tuser[2:0] !== want.msg)
                    report($sformatf("message expected %0d, got %0d", want.msg, m_tuser[2:0]));
                if (m_tdata[16:1] !== want.secs)
                    report($sformatf("seconds_left expected %0d, got %0d", want.secs,
                                     m_tdata[16:1]));
                if (m_tlast !== want.last)
                    report($sformatf("last expected %0b, got %0b", want.last, m_tlast));
            end
        end
    end

    initial
    begin
        #500_000;
        $display("CHECK FAILED");
        $finish;
    end

    // Main sequence: reset, directed table, then random phases per setting
    initial
    begin
        logic [9:0]  hot_set[N_PHASES];
        logic [9:0]  cold_set[N_PHASES];
        logic [15:0] quick_set[N_PHASES];

        hot_set   = '{10'd600, 10'd1023, 10'd0,    10'd300, 10'd512};
        cold_set  = '{10'd100, 10'd0,    10'd1023, 10'd200, 10'd511};
        quick_set = '{16'd2000, 16'd1,   16'd0,    16'hFFFF, 16'd7};

        // rejections while cold, first heat-up, timer limits, locking
        dir_tab[0]  = typed_row(CMD_QUICK,   10'd0,    16'd0,    16'd0,    0, 0, MSG_READY, 0);
        dir_tab[1]  = typed_row(CMD_MANUAL,  10'd0,    16'd0,    16'd0,    0, 0, MSG_READY, 0);
        dir_tab[2]  = typed_row(CMD_TIMER,   10'd0,    16'd5,    16'd5,    0, 0, MSG_READY, 0);
        dir_tab[3]  = item_of(CMD_REFRESH,   10'd0,    16'd0,    16'd0);
        dir_tab[4]  = typed_row(CMD_TICK,    10'd0,    16'd0,    16'd0,    0, 0, MSG_READY, 0);
        dir_tab[5]  = typed_row(CMD_TICK,    10'h3FF,  16'd0,    16'd0,    1, 0, MSG_READY, 0);
        dir_tab[6]  = typed_row(CMD_TIMER,   10'd0,    16'd0,    16'd5,    0, 0, MSG_READY, 0);
        dir_tab[7]  = typed_row(CMD_TIMER,   10'd0,    16'd5,    16'd0,    0, 0, MSG_READY, 0);
        dir_tab[8]  = typed_row(CMD_TIMER,   10'd0,    16'hFFFF, 16'hFFFF, 1, 0, MSG_TIMER,
                                16'hFFFF);
        dir_tab[9]  = item_of(CMD_REFRESH,   10'h3FF,  16'hFFFF, 16'hFFFF);
        dir_tab[10] = typed_row(CMD_MANUAL,  10'd0,    16'd0,    16'd0,    0, 0, MSG_READY, 0);
        dir_tab[11] = typed_row(CMD_QUICK,   10'd0,    16'd0,    16'd0,    1, 1, MSG_FOG, 0);
        dir_tab[12] = typed_row(CMD_QUICK,   10'd0,    16'd0,    16'd0,    0, 0, MSG_READY, 0);
        // reset turns the relay off but leaves the burst countdown running
        dir_tab[13] = typed_row(CMD_RESET,   10'd0,    16'd0,    16'd0,    1, 0, MSG_RESET, 0);
        dir_tab[14] = typed_row(CMD_MANUAL,  10'd0,    16'd0,    16'd0,    1, 1, MSG_MANUAL, 0);
        dir_tab[15] = typed_row(CMD_MANUAL,  10'd0,    16'd0,    16'd0,    1, 0, MSG_RESET, 0);
        dir_tab[16] = typed_row(CMD_LOCK,    10'd0,    16'd0,    16'd0,    1, 0, MSG_LOCKED, 0);
        dir_tab[17] = typed_row(CMD_LOCK,    10'd0,    16'd0,    16'd0,    0, 0, MSG_READY, 0);
        dir_tab[18] = typed_row(CMD_QUICK,   10'd0,    16'd0,    16'd0,    0, 0, MSG_READY, 0);
        dir_tab[19] = typed_row(CMD_MANUAL,  10'd0,    16'd0,    16'd0,    0, 0, MSG_READY, 0);
        dir_tab[20] = typed_row(CMD_TIMER,   10'd0,    16'd3,    16'd3,    0, 0, MSG_READY, 0);
        dir_tab[21] = item_of(CMD_REFRESH,   10'd0,    16'd0,    16'd0);
        dir_tab[22] = typed_row(CMD_UNLOCK,  10'd0,    16'd0,    16'd0,    1, 0, MSG_UNLOCKED, 0);
        dir_tab[23] = typed_row(CMD_UNLOCK,  10'd0,    16'd0,    16'd0,    0, 0, MSG_READY, 0);
        dir_tab[24] = item_of(CMD_TICK,      10'd50,   16'd0,    16'd0);
        dir_tab[25] = item_of(CMD_REFRESH,   10'd0,    16'd0,    16'd0);

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < DIR_ROWS; r++)
            drive_item(dir_tab[r]);

        for (int p = 0; p < N_PHASES; p++)
        begin
            if (p > 0)
            begin
                wait_idle();
                apb_write(CFG_HOT, {22'd0, hot_set[p]});
                apb_write(CFG_COLD, {22'd0, cold_set[p]});
                apb_write(CFG_QUICK, {16'd0, quick_set[p]});
            end
            else
            begin
                // refreshes always answer, so these pile up behind the hold-off
                hold_req = 1'b1;
                repeat (16)
                    drive_item(item_of(CMD_REFRESH, 10'($urandom()), 16'($urandom()),
                                       16'($urandom())));
            end
            random_phase(PHASE_ITEMS);
        end

        wait_idle();
        if (err_cnt == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
